FILE: rtl/core/fixed_point_alu_q24_8_top_assert.svh
// Assertion macros for the fixed-point ALU RTL.
// Depends on nothing; included by the top module, which checks its own logic.
`ifndef FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define FPA_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("fpa check failed");

// Antecedent implies consequent in the same cycle.
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpa check failed");

`endif

FILE: rtl/core/fpa_pkg.sv
// Types, op codes and constants of the Q24.8 fixed-point ALU.
// No dependencies; used by every module of the block.
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DIV_STEPS = 32;

   localparam logic signed [63:0] MAX_RAW = 64'sd2147483647;
   localparam logic signed [63:0] MIN_RAW = -64'sd2147483648;
   localparam logic [63:0] HALF_LSB = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
   localparam logic signed [63:0] BIG_MAG = 64'sd1 << 40;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] a_raw;
      logic signed [31:0] b_raw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_raw;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
      logic               overflow;
      logic               div_zero;
   } rsp_type;

   // Item in flight through the divider row.
   typedef struct packed {
      logic [3:0]         op;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
      logic signed [63:0] wide;   // unsaturated result, or raw product for mul
      logic               neg;    // quotient sign
      logic               big;    // quotient certainly beyond 32 bits
      logic               dz;
      logic [31:0]        den;
      logic [32:0]        rem;
      logic [31:0]        num;    // dividend bits still to shift in
      logic [31:0]        quo;
   } stage_type;

endpackage

FILE: rtl/core/fpa_front.sv
// Entry stage: simple ops, 32x32 product, divider setup.
// Depends on fpa_pkg.
module fpa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpa_pkg::stage_type out_data
);

   logic               valid_ff;
   fpa_pkg::stage_type data_ff, data_in;
   logic signed [63:0] a64, b64, prod;
   logic [31:0]        mag_a, mag_b;
   logic [63:0]        numer;

   always_comb begin
      a64   = {{32{in_data.a_raw[31]}}, in_data.a_raw};
      b64   = {{32{in_data.b_raw[31]}}, in_data.b_raw};
      prod  = in_data.a_raw * in_data.b_raw;
      mag_a = in_data.a_raw[31] ? 32'(-a64) : in_data.a_raw;
      mag_b = in_data.b_raw[31] ? 32'(-b64) : in_data.b_raw;
      numer = {32'd0, mag_a} << fpa_pkg::FRAC_BITS;

      data_in.op        = in_data.op;
      data_in.a_less    = in_data.a_raw < in_data.b_raw;
      data_in.a_equal   = in_data.a_raw == in_data.b_raw;
      data_in.a_greater = in_data.a_raw > in_data.b_raw;
      data_in.neg       = in_data.a_raw[31] ^ in_data.b_raw[31];
      data_in.big       = numer[63:32] >= mag_b;
      data_in.dz        = (in_data.op == fpa_pkg::OP_DIV) && (in_data.b_raw == 32'sd0);
      data_in.den       = mag_b;
      data_in.rem       = data_in.big ? 33'd0 : {1'b0, numer[63:32]};
      data_in.num       = numer[31:0];
      data_in.quo       = 32'd0;
      case (in_data.op)
         fpa_pkg::OP_ADD:      data_in.wide = a64 + b64;
         fpa_pkg::OP_SUB:      data_in.wide = a64 - b64;
         fpa_pkg::OP_MUL:      data_in.wide = prod;
         fpa_pkg::OP_MIN:      data_in.wide = data_in.a_less ? a64 : b64;
         fpa_pkg::OP_MAX:      data_in.wide = data_in.a_greater ? a64 : b64;
         fpa_pkg::OP_INC:      data_in.wide = a64 + 64'sd1;
         fpa_pkg::OP_DEC:      data_in.wide = a64 - 64'sd1;
         fpa_pkg::OP_TO_INT:   data_in.wide = a64 >>> fpa_pkg::FRAC_BITS;
         fpa_pkg::OP_FROM_INT: data_in.wide = a64 <<< fpa_pkg::FRAC_BITS;
         default:              data_in.wide = 64'sd0;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/fpa_div_cell.sv
// One restoring-division cell: one quotient bit per beat, passes the rest on.
// Depends on fpa_pkg.
module fpa_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fpa_pkg::stage_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fpa_pkg::stage_type out_data
);

   logic               valid_ff;
   fpa_pkg::stage_type data_ff, data_in;
   logic [32:0]        trial;
   logic               take;

   always_comb begin
      trial   = {in_data.rem[31:0], in_data.num[31]};
      take    = trial >= {1'b0, in_data.den};
      data_in = in_data;
      data_in.rem = take ? trial - {1'b0, in_data.den} : trial;
      data_in.num = {in_data.num[30:0], 1'b0};
      data_in.quo = {in_data.quo[30:0], take};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/fpa_back.sv
// Output stage: mul and div rounding, saturation, result register.
// Depends on fpa_pkg.
module fpa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fpa_pkg::stage_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fpa_pkg::rsp_type   out_data
);

   logic               valid_ff;
   fpa_pkg::rsp_type   data_ff, data_in;
   logic [63:0]        pmag, pround;
   logic [32:0]        qmag;
   logic signed [63:0] qval, value;

   always_comb begin
      pmag   = in_data.wide[63] ? 64'(-in_data.wide) : 64'(in_data.wide);
      pround = (pmag + fpa_pkg::HALF_LSB) >> fpa_pkg::FRAC_BITS;
      qmag   = {1'b0, in_data.quo} +
               33'({in_data.rem, 1'b0} >= {2'b00, in_data.den});
      qval   = $signed(64'(qmag));
      case (in_data.op)
         fpa_pkg::OP_MUL: value = in_data.wide[63] ? -$signed(pround) : $signed(pround);
         fpa_pkg::OP_DIV: begin
            if (in_data.big) begin
               value = in_data.neg ? -fpa_pkg::BIG_MAG : fpa_pkg::BIG_MAG;
            end else begin
               value = in_data.neg ? -qval : qval;
            end
         end
         default: value = in_data.wide;
      endcase

      data_in.a_less    = in_data.a_less;
      data_in.a_equal   = in_data.a_equal;
      data_in.a_greater = in_data.a_greater;
      data_in.div_zero  = in_data.dz;
      if (in_data.dz) begin
         data_in.result_raw = 32'sd0;
         data_in.overflow   = 1'b0;
      end else if (value > fpa_pkg::MAX_RAW) begin
         data_in.result_raw = 32'(fpa_pkg::MAX_RAW);
         data_in.overflow   = 1'b1;
      end else if (value < fpa_pkg::MIN_RAW) begin
         data_in.result_raw = 32'(fpa_pkg::MIN_RAW);
         data_in.overflow   = 1'b1;
      end else begin
         data_in.result_raw = value[31:0];
         data_in.overflow   = 1'b0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: rtl/core/fixed_point_alu_q24_8_top.sv
// Q24.8 fixed-point ALU: entry stage, row of division cells, output stage.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back and the assert header.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one op beat: op, a_raw, b_raw.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result beat per op,
//    in issue order: result_raw, compare flags, overflow, div_zero.
//  - Every op takes the same path: 1 entry stage, 32 division cells, 1 output stage.
//  - Throughput is one beat per cycle while rsp_ready is high; the 32 cells each resolve one quotient
//    bit of a divide, and the entry stage holds the single 32x32 multiplier.
//  - Every stage holds one beat and is ready when empty or when its
//    successor moves, so a stalled rsp side fills the row from the back;
//    req_ready drops only once all 34 stages hold a beat.
//  - Synchronous active-high reset empties every stage; nothing else is
//    cleared. No configuration.
`include "fixed_point_alu_q24_8_top_assert.svh"

module fixed_point_alu_q24_8_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fpa_pkg::rsp_type rsp_data
);

   // Chain links: index 0 is the entry stage output, DIV_STEPS the last cell.
   logic               link_valid [fpa_pkg::DIV_STEPS + 1];
   logic               link_ready [fpa_pkg::DIV_STEPS + 1];
   fpa_pkg::stage_type link_data  [fpa_pkg::DIV_STEPS + 1];

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // One cell per quotient bit, most significant first.
   for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i + 1]),
         .out_ready (link_ready[i + 1]),
         .out_data  (link_data[i + 1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[fpa_pkg::DIV_STEPS]),
      .in_ready  (link_ready[fpa_pkg::DIV_STEPS]),
      .in_data   (link_data[fpa_pkg::DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // Exactly one compare flag per result beat.
   `FPA_ASSERT_IMPL(a_flags_onehot, clock, reset, rsp_valid,
      $onehot({rsp_data.a_less, rsp_data.a_equal, rsp_data.a_greater}))
   // Divide by zero gives zero and no overflow.
   `FPA_ASSERT_IMPL(a_div_zero_clean, clock, reset, rsp_valid && rsp_data.div_zero,
      (rsp_data.result_raw == 32'sd0) && !rsp_data.overflow)
   // Saturated results sit at a range limit.
   `FPA_ASSERT_IMPL(a_ovf_limit, clock, reset, rsp_valid && rsp_data.overflow,
      (rsp_data.result_raw == 32'sh7fffffff) || (rsp_data.result_raw == 32'sh80000000))
   // Back pressure reaches the input only through a full entry stage.
   `FPA_ASSERT_IMPL(a_ready_full, clock, reset, !req_ready, link_valid[0] && rsp_valid)

endmodule
